[src/uicv_pkg.sv]
// Shared types, codes and the CRC-32 byte function of the update image verifier.
package uicv_pkg;

   localparam logic [31:0] MAGIC_RESET   = 32'h4F54_4131;
   localparam logic [31:0] MAX_LEN_RESET = 32'd51200;
   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

   localparam logic CSR_IMAGE_MAGIC = 1'b0;
   localparam logic CSR_MAX_LENGTH  = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_DATA   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_NONE_PENDING = 3'd0,
      STATUS_HEADER_ERROR = 3'd1,
      STATUS_BAD_LENGTH   = 3'd2,
      STATUS_DATA_ERROR   = 3'd3,
      STATUS_CRC_MISMATCH = 3'd4,
      STATUS_VERIFIED     = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
      logic       read_failed;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        clear_header;
      logic [31:0] image_length;
      logic [31:0] target_address;
      logic [31:0] computed_crc;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[src/update_image_crc_verifier_core.sv]
// Update image CRC-32 verifier top level: input register, engine, result register.
// A result is held in the result register once the engine takes its item from the input register.
// Throughput: one byte per cycle while not stalled, set by the eight-step CRC byte network in the engine.
// The input stalls only while its register is full and a result waits under rsp_stall.
// Reset (synchronous): pipeline empty, phase idle, CRC all ones, registers at defaults.
module update_image_crc_verifier_core import uicv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_item_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_item_ff;
   logic [31:0] magic_ff, max_len_ff;

   logic    out_free, advance, fire;
   rsp_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   uicv_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (in_item_ff),
      .image_magic (magic_ff),
      .max_length  (max_len_ff),
      .rsp_fire    (fire),
      .rsp         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (advance && fire) begin
         out_item_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= MAGIC_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_MAGIC: magic_ff   <= csr_wr_data;
            CSR_MAX_LENGTH:  max_len_ff <= csr_wr_data;
            default:         magic_ff   <= magic_ff;
         endcase
      end
   end

   a_clear_matches_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_item_ff.clear_header ==
         (out_item_ff.status != STATUS_NONE_PENDING &&
          out_item_ff.status != STATUS_HEADER_ERROR)))
      else $error("clear_header disagrees with status");

   a_crc_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.status != STATUS_VERIFIED &&
       out_item_ff.status != STATUS_CRC_MISMATCH) |-> (out_item_ff.computed_crc == 32'd0))
      else $error("computed_crc set without a finished CRC");

   a_hold_on_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input item lost while result stalled");

   a_header_error_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.status == STATUS_HEADER_ERROR) |->
         (out_item_ff.image_length == 32'd0 && out_item_ff.target_address == 32'd0))
      else $error("header read error reports header words");

endmodule

[src/uicv_engine.sv]
// Header parse, length check and running CRC state for one byte per cycle while advance is high.
module uicv_engine import uicv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  req_type     item,
   input  logic [31:0] image_magic,
   input  logic [31:0] max_length,
   output logic        rsp_fire,
   output rsp_type     rsp
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] magic_ff, magic_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] crc_word_ff, crc_word_in;
   logic [31:0] target_ff, target_in;
   logic [31:0] running_ff, running_in;
   logic [31:0] left_ff, left_in;

   phase_type   eff_phase;
   logic [3:0]  eff_count;
   logic [31:0] eff_magic, eff_length, eff_crc_word, eff_target, eff_running, eff_left;
   logic [31:0] byte_word, next_running, fin;

   always_comb begin
      eff_phase    = item.image_start ? PHASE_HEADER : phase_ff;
      eff_count    = item.image_start ? 4'd0 : count_ff;
      eff_magic    = item.image_start ? 32'd0 : magic_ff;
      eff_length   = item.image_start ? 32'd0 : length_ff;
      eff_crc_word = item.image_start ? 32'd0 : crc_word_ff;
      eff_target   = item.image_start ? 32'd0 : target_ff;
      eff_running  = item.image_start ? CRC_INIT : running_ff;
      eff_left     = item.image_start ? 32'd0 : left_ff;

      byte_word    = {24'd0, item.data_byte} << {eff_count[1:0], 3'b000};
      next_running = crc_byte(eff_running, item.data_byte);
      fin          = ~next_running;

      phase_in    = eff_phase;
      count_in    = eff_count;
      magic_in    = eff_magic;
      length_in   = eff_length;
      crc_word_in = eff_crc_word;
      target_in   = eff_target;
      running_in  = eff_running;
      left_in     = eff_left;

      rsp_fire            = 1'b0;
      rsp.status          = STATUS_NONE_PENDING;
      rsp.clear_header    = 1'b0;
      rsp.image_length    = 32'd0;
      rsp.target_address  = 32'd0;
      rsp.computed_crc    = 32'd0;

      case (eff_phase)
         PHASE_HEADER: begin
            if (item.read_failed) begin
               rsp_fire   = 1'b1;
               rsp.status = STATUS_HEADER_ERROR;
               phase_in   = PHASE_IDLE;
            end else begin
               case (eff_count[3:2])
                  2'd0:    magic_in    = eff_magic | byte_word;
                  2'd1:    length_in   = eff_length | byte_word;
                  2'd2:    crc_word_in = eff_crc_word | byte_word;
                  default: target_in   = eff_target | byte_word;
               endcase
               count_in = eff_count + 4'd1;
               if (eff_count == 4'd15) begin
                  rsp.image_length   = length_in;
                  rsp.target_address = target_in;
                  if (magic_in != image_magic) begin
                     rsp_fire   = 1'b1;
                     rsp.status = STATUS_NONE_PENDING;
                     phase_in   = PHASE_IDLE;
                  end else if (length_in == 32'd0 || length_in > max_length) begin
                     rsp_fire         = 1'b1;
                     rsp.status       = STATUS_BAD_LENGTH;
                     rsp.clear_header = 1'b1;
                     phase_in         = PHASE_IDLE;
                  end else begin
                     phase_in   = PHASE_DATA;
                     left_in    = length_in;
                     running_in = CRC_INIT;
                  end
               end
            end
         end
         PHASE_DATA: begin
            rsp.image_length   = eff_length;
            rsp.target_address = eff_target;
            rsp.clear_header   = 1'b1;
            if (item.read_failed) begin
               rsp_fire   = 1'b1;
               rsp.status = STATUS_DATA_ERROR;
               phase_in   = PHASE_IDLE;
            end else begin
               running_in = next_running;
               left_in    = eff_left - 32'd1;
               if (eff_left == 32'd1) begin
                  rsp_fire         = 1'b1;
                  rsp.computed_crc = fin;
                  rsp.status       = (fin == eff_crc_word) ? STATUS_VERIFIED
                                                           : STATUS_CRC_MISMATCH;
                  phase_in         = PHASE_IDLE;
               end
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_IDLE;
         count_ff   <= 4'd0;
         running_ff <= CRC_INIT;
         left_ff    <= 32'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         running_ff <= running_in;
         left_ff    <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         magic_ff    <= magic_in;
         length_ff   <= length_in;
         crc_word_ff <= crc_word_in;
         target_ff   <= target_in;
      end
   end

endmodule

[test/update_image_crc_verifier_checker.sv]
// Checker for the update image CRC verifier: watches both channels, predicts verdicts, compares.
`timescale 1ns / 1ps

module update_image_crc_verifier_checker import uicv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_item,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_item,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,
   output int          error_count,
   output int          pending_count
);

   localparam int REPORT_LIMIT = 10;

   logic [31:0] magic_reg;
   logic [31:0] max_len_reg;
   phase_type   phase;
   logic [4:0]  hdr_count;
   logic [31:0] hdr_magic;
   logic [31:0] hdr_len;
   logic [31:0] hdr_crc;
   logic [31:0] hdr_target;
   logic [31:0] crc_acc;
   logic [31:0] bytes_left;
   rsp_type     verdict_q[$];
   int          mismatches;

   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ ({32{c[0] ^ data[i]}} & CRC_POLY);
      end
      return c;
   endfunction

   task automatic post_verdict(input status_type st, input logic clr, input logic [31:0] len,
                               input logic [31:0] tgt, input logic [31:0] crc);
      verdict_q.push_back(rsp_type'{status: st, clear_header: clr, image_length: len,
                                    target_address: tgt, computed_crc: crc});
      phase = PHASE_IDLE;
   endtask

   task automatic predict_verdict(input req_type it);
      logic [31:0] fin;
      if (it.image_start) begin
         phase      = PHASE_HEADER;
         hdr_count  = '0;
         hdr_magic  = '0;
         hdr_len    = '0;
         hdr_crc    = '0;
         hdr_target = '0;
         crc_acc    = CRC_INIT;
         bytes_left = '0;
      end
      case (phase)
         PHASE_HEADER: begin
            if (it.read_failed) begin
               post_verdict(STATUS_HEADER_ERROR, 1'b0, '0, '0, '0);
            end else begin
               case (hdr_count[3:2])
                  2'd0: hdr_magic[8 * hdr_count[1:0] +: 8] = it.data_byte;
                  2'd1: hdr_len[8 * hdr_count[1:0] +: 8] = it.data_byte;
                  2'd2: hdr_crc[8 * hdr_count[1:0] +: 8] = it.data_byte;
                  default: hdr_target[8 * hdr_count[1:0] +: 8] = it.data_byte;
               endcase
               hdr_count = hdr_count + 5'd1;
               if (hdr_count == 5'd16) begin
                  if (hdr_magic != magic_reg) begin
                     post_verdict(STATUS_NONE_PENDING, 1'b0, hdr_len, hdr_target, '0);
                  end else if (hdr_len == 0 || hdr_len > max_len_reg) begin
                     post_verdict(STATUS_BAD_LENGTH, 1'b1, hdr_len, hdr_target, '0);
                  end else begin
                     phase      = PHASE_DATA;
                     bytes_left = hdr_len;
                     crc_acc    = CRC_INIT;
                  end
               end
            end
         end
         PHASE_DATA: begin
            if (it.read_failed) begin
               post_verdict(STATUS_DATA_ERROR, 1'b1, hdr_len, hdr_target, '0);
            end else begin
               crc_acc    = crc_update(crc_acc, it.data_byte);
               bytes_left = bytes_left - 32'd1;
               if (bytes_left == 0) begin
                  fin = ~crc_acc;
                  post_verdict((fin == hdr_crc) ? STATUS_VERIFIED : STATUS_CRC_MISMATCH, 1'b1,
                               hdr_len, hdr_target, fin);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         magic_reg   = MAGIC_RESET;
         max_len_reg = MAX_LEN_RESET;
         phase       = PHASE_IDLE;
         hdr_count   = '0;
         hdr_magic   = '0;
         hdr_len     = '0;
         hdr_crc     = '0;
         hdr_target  = '0;
         crc_acc     = CRC_INIT;
         bytes_left  = '0;
         verdict_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_MAGIC: magic_reg = csr_wr_data;
               CSR_MAX_LENGTH:  max_len_reg = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: status %0d clr %0d len %h tgt %h crc %h",
                           rsp_item.status, rsp_item.clear_header, rsp_item.image_length,
                           rsp_item.target_address, rsp_item.computed_crc);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_item.status !== want.status
                   || rsp_item.clear_header !== want.clear_header
                   || rsp_item.image_length !== want.image_length
                   || rsp_item.target_address !== want.target_address
                   || rsp_item.computed_crc !== want.computed_crc) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("mismatch: expected status %0d clr %0d len %h tgt %h crc %h",
                              want.status, want.clear_header, want.image_length,
                              want.target_address, want.computed_crc);
                     $display("          actual   status %0d clr %0d len %h tgt %h crc %h",
                              rsp_item.status, rsp_item.clear_header, rsp_item.image_length,
                              rsp_item.target_address, rsp_item.computed_crc);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            predict_verdict(req_item);
      end
      error_count   <= mismatches;
      pending_count <= verdict_q.size();
   end

endmodule

[test/update_image_crc_verifier_core_tb.sv]
// Testbench top for the update image CRC verifier: clock, reset, image stimulus and verdict.
`timescale 1ns / 1ps

module update_image_crc_verifier_core_tb import uicv_pkg::*; ();

   localparam int ITEM_TARGET  = 1200;
   localparam int CHUNKS       = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 6;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_item    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_item;
   logic        csr_wr_en   = 1'b0;
   logic        csr_index   = CSR_IMAGE_MAGIC;
   logic [31:0] csr_wr_data = '0;

   int          error_count;
   int          pending_count;
   int          cycles;
   int          items_sent;
   int          send_idle_pct = 31;
   int          recv_idle_pct = 55;
   logic [31:0] magic_cfg     = MAGIC_RESET;
   logic [31:0] max_len_cfg   = MAX_LEN_RESET;

   update_image_crc_verifier_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   update_image_crc_verifier_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic start, input logic failed);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{data_byte: data, image_start: start, read_failed: failed};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
   endtask

   // fail_pos marks the item sent with a read failure; cut stops the image early
   task automatic send_image(input logic [31:0] magic, input logic [31:0] len_word,
                             input logic [31:0] target, input int data_count,
                             input bit crc_ok, input int fail_pos, input int cut);
      logic [7:0]   data_q[$];
      logic [31:0]  crc;
      logic [127:0] header;
      logic [7:0]   data;
      logic         failed;
      int           stop;
      crc = CRC_INIT;
      for (int i = 0; i < data_count; i++) begin
         data = 8'($urandom);
         data_q.push_back(data);
         crc = crc_byte(crc, data);
      end
      crc = ~crc;
      if (!crc_ok)
         crc = crc ^ ($urandom | 32'd1);
      header = {target, crc, len_word, magic};
      stop = (cut >= 0) ? cut : 16 + data_count;
      for (int i = 0; i < stop; i++) begin
         data   = (i < 16) ? header[8 * i +: 8] : data_q[i - 16];
         failed = (i == fail_pos);
         send_byte(data, i == 0, failed);
         items_sent++;
         if (failed)
            break;
      end
   endtask

   task automatic random_image();
      int          pick;
      int          dlen;
      logic [31:0] target;
      logic [31:0] bad_len;
      pick   = $urandom_range(0, 99);
      dlen   = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      target = $urandom;
      if (dlen > max_len_cfg)
         dlen = max_len_cfg;
      if (pick < 55) begin
         send_image(magic_cfg, dlen, target, dlen, $urandom_range(0, 3) != 0, -1, -1);
      end else if (pick < 63) begin
         send_image(magic_cfg, dlen, target, dlen, 1'b1, 16 + $urandom_range(0, dlen - 1), -1);
      end else if (pick < 70) begin
         send_image(magic_cfg, dlen, target, dlen, 1'b1, $urandom_range(0, 15), -1);
      end else if (pick < 77) begin
         send_image(magic_cfg ^ ($urandom | 32'd1), $urandom, target, 0, 1'b1, -1, -1);
      end else if (pick < 84) begin
         case ($urandom_range(0, 2))
            0: bad_len = '0;
            1: bad_len = 32'hFFFF_FFFF;
            default: bad_len = max_len_cfg + 32'd1 + $urandom_range(0, 7);
         endcase
         if (max_len_cfg > 32'hFFFF_FFF0)
            bad_len = '0;
         send_image(magic_cfg, bad_len, target, 0, 1'b1, -1, -1);
      end else if (pick < 92) begin
         send_image(magic_cfg, dlen, target, dlen, 1'b1, -1, $urandom_range(1, 15 + dlen));
      end else begin
         send_noise($urandom_range(1, 4));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [31:0] magic, input logic [31:0] max_len);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_IMAGE_MAGIC;
      csr_wr_data <= magic;
      @(posedge clock);
      csr_index   <= CSR_MAX_LENGTH;
      csr_wr_data <= max_len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      magic_cfg   = magic;
      max_len_cfg = max_len;
   endtask

   initial begin
      logic [31:0] magic_set[CHUNKS];
      logic [31:0] limit_set[CHUNKS];
      int          first;
      magic_set = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, MAGIC_RESET, $urandom, $urandom};
      limit_set = '{32'd1, 32'hFFFF_FFFF, $urandom_range(8, 64), MAX_LEN_RESET, 32'd16,
                    $urandom_range(1, 4)};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_image(MAGIC_RESET, 32'd1, 32'h0000_0000, 1, 1'b1, -1, -1);
      send_image(MAGIC_RESET, 32'd4, 32'hFFFF_FFFF, 4, 1'b0, -1, -1);
      send_image(~MAGIC_RESET, 32'hFFFF_FFFF, 32'h0800_0000, 0, 1'b1, -1, -1);
      send_image(MAGIC_RESET, 32'd0, $urandom, 0, 1'b1, -1, -1);
      send_image(MAGIC_RESET, MAX_LEN_RESET + 32'd1, $urandom, 0, 1'b1, -1, -1);
      send_image(MAGIC_RESET, 32'd2, $urandom, 2, 1'b1, 0, -1);
      send_image(MAGIC_RESET, 32'd2, $urandom, 2, 1'b1, 15, -1);
      send_image(MAGIC_RESET, 32'd3, $urandom, 3, 1'b1, 17, -1);
      send_image(MAGIC_RESET, 32'd3, $urandom, 3, 1'b1, -1, 7);
      send_image(MAGIC_RESET, 32'd3, $urandom, 3, 1'b1, -1, 17);
      send_image(MAGIC_RESET, 32'd3, $urandom, 3, 1'b1, -1, -1);
      drain();
      load_config(MAGIC_RESET, 32'hFFFF_FFFF);
      send_image(MAGIC_RESET, 32'hFFFF_FFFF, $urandom, 3, 1'b1, -1, 19);
      send_image(MAGIC_RESET, 32'd2, $urandom, 2, 1'b1, -1, -1);

      for (int c = 0; c < CHUNKS; c++) begin
         if (c == 2) begin
            send_idle_pct = 55;
            recv_idle_pct = 31;
         end else if (c == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         load_config(magic_set[c], limit_set[c]);
         first = items_sent;
         while (items_sent - first < ITEM_TARGET / CHUNKS)
            random_image();
      end
      drain();

      if (error_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
